// File: hw/rtl/krfs_pkg.sv
// Shared types, constants and codes of the keyed random fragment splitter.
package krfs_pkg;

  localparam int unsigned FragW            = 32;
  localparam int unsigned OffW             = 64;
  localparam int unsigned DivRemW          = FragW + 1;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 64;
  localparam int unsigned DrawsPerChunk    = 4;
  localparam int unsigned MaxChunksDefault = 8192;

  localparam logic [CfgIdxW-1:0] CfgFragMin    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFragAvg    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFragMax    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFragAlign  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStreamSize = 3'd4;

  typedef enum logic [1:0] {
    StFragment   = 2'd0,
    StBadProfile = 2'd1,
    StBudget     = 2'd2,
    StIdle       = 2'd3
  } krfs_status_e;

  typedef enum logic [3:0] {
    SIdle,
    SProfIssue,
    SProfWait,
    SDecide,
    SBudget,
    SBudCheck,
    SDrawIssue,
    SDrawWait,
    SMul,
    SCut,
    SEmit
  } krfs_state_e;

  typedef struct packed {
    logic [FragW-1:0] draw_value;
    logic             begin_split;
  } krfs_in_t;

  typedef struct packed {
    logic [OffW-1:0]  fragment_offset;
    logic [FragW-1:0] fragment_length;
    logic             is_last;
    krfs_status_e     status;
  } krfs_out_t;

  typedef struct packed {
    logic               start;
    logic [FragW-1:0]   dividend;
    logic [DivRemW-1:0] divisor;
  } krfs_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [FragW-1:0]   quot;
    logic [DivRemW-1:0] rem;
  } krfs_div_rsp_t;

endpackage

// File: hw/rtl/krfs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module krfs_div import krfs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  krfs_div_req_t req_i,
  output krfs_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(FragW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [FragW-1:0]    quo_q, quo_d;
  logic [DivRemW-1:0]  rem_q, rem_d;
  logic [DivRemW-1:0]  dvs_q, dvs_d;
  logic [DivRemW:0]    trial;
  logic [DivRemW+1:0]  diff;
  logic                ge;

  assign trial = {rem_q, quo_q[FragW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[DivRemW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivRemW-1:0] : trial[DivRemW-1:0];
      quo_d = {quo_q[FragW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(FragW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: hw/rtl/keyed_random_fragment_splitter_unit.sv
// Top level of the keyed random fragment splitter.
// One random draw in, one result out. A draw that continues a split is reduced modulo the unit
// range by the shared divider, then multiplied and cut; a draw that begins a split first passes
// the budget multiply and compare. The profile quotients and remainders are kept between draws;
// the first draw after a write to frag_min, frag_avg, frag_max or frag_align reruns three
// divisions on the same divider, unless frag_align is zero. The input is not ready while a draw
// is at work; a finished result waits in the output register while the next draw is transferred.
module keyed_random_fragment_splitter_unit import krfs_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = MaxChunksDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  krfs_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output krfs_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned DrawBudget = MAX_CHUNKS * DrawsPerChunk;
  localparam int unsigned BudLimit   = DrawBudget - 1;
  localparam int unsigned BudW       = $clog2(DrawBudget);
  localparam int unsigned ProdW      = FragW + BudW;

  krfs_state_e state_q, state_d;

  logic [FragW-1:0] frag_min_q, frag_avg_q, frag_max_q, frag_align_q;
  logic [OffW-1:0]  stream_size_q;

  logic [OffW-1:0]  offset_q, offset_d;
  logic             active_q, active_d;
  logic             cache_ok_q, cache_ok_d;
  logic             prof_ok_q, prof_ok_d;
  logic [FragW-1:0] umin_q, umin_d;
  logic [FragW-1:0] umax_q, umax_d;
  logic [1:0]       rz_q, rz_d;
  logic [1:0]       phase_q, phase_d;
  logic [FragW-1:0] draw_q;
  logic             begin_q;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [FragW-1:0] rmod_q, rmod_d;
  logic [FragW-1:0] mul_q, mul_d;
  krfs_out_t        res_q, res_d;
  krfs_out_t        out_q;
  logic             out_valid_q;

  krfs_div_req_t    div_req;
  krfs_div_rsp_t    div_rsp;

  logic             accept;
  logic             cfg_prof_wr;
  logic             rem_zero;
  logic [DivRemW-1:0] range;
  logic [OffW-1:0]  left;
  logic [OffW-1:0]  wanted;
  logic             cut_short;
  logic [OffW-1:0]  cut_len;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_prof_wr = cfg_we_i && (cfg_idx_i == CfgFragMin || cfg_idx_i == CfgFragAvg ||
                                    cfg_idx_i == CfgFragMax || cfg_idx_i == CfgFragAlign);
  assign rem_zero    = (div_rsp.rem == '0);
  assign range       = {1'b0, umax_q} - {1'b0, umin_q} + DivRemW'(1);
  assign left        = stream_size_q - offset_q;
  assign wanted      = {{(OffW-FragW){1'b0}}, frag_min_q + mul_q};
  assign cut_short   = (wanted < left);
  assign cut_len     = cut_short ? wanted : left;

  krfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:      if (accept) state_d = cache_ok_q ? SDecide : SProfIssue;
      SProfIssue: state_d = (frag_align_q == '0) ? SDecide : SProfWait;
      SProfWait: begin
        if (div_rsp.done) state_d = (phase_q == 2'd2) ? SDecide : SProfIssue;
      end
      SDecide: begin
        if (begin_q) begin
          state_d = prof_ok_q ? SBudget : SEmit;
        end else if (!active_q || !prof_ok_q || offset_q >= stream_size_q) begin
          state_d = SEmit;
        end else begin
          state_d = SDrawIssue;
        end
      end
      SBudget:    state_d = SBudCheck;
      SBudCheck: begin
        if (stream_size_q > OffW'(prod_q) || stream_size_q == '0) state_d = SEmit;
        else state_d = SDrawIssue;
      end
      SDrawIssue: state_d = SDrawWait;
      SDrawWait:  if (div_rsp.done) state_d = SMul;
      SMul:       state_d = SCut;
      SCut:       state_d = SEmit;
      SEmit:      if (!out_valid_q || out_ready_i) state_d = SIdle;
      default:    state_d = SIdle;
    endcase
  end

  always_comb begin
    offset_d         = offset_q;
    active_d         = active_q;
    cache_ok_d       = cache_ok_q;
    prof_ok_d        = prof_ok_q;
    umin_d           = umin_q;
    umax_d           = umax_q;
    rz_d             = rz_q;
    phase_d          = phase_q;
    prod_d           = prod_q;
    rmod_d           = rmod_q;
    mul_d            = mul_q;
    res_d            = res_q;
    div_req.start    = 1'b0;
    div_req.dividend = draw_q;
    div_req.divisor  = range;
    in_ready_o       = (state_q == SIdle);
    unique case (state_q)
      SIdle: begin
        phase_d = 2'd0;
      end
      SProfIssue: begin
        if (frag_align_q == '0) begin
          prof_ok_d  = 1'b0;
          cache_ok_d = 1'b1;
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = {1'b0, frag_align_q};
          case (phase_q)
            2'd0:    div_req.dividend = frag_min_q;
            2'd1:    div_req.dividend = frag_avg_q;
            default: div_req.dividend = frag_max_q;
          endcase
        end
      end
      SProfWait: begin
        if (div_rsp.done) begin
          phase_d = phase_q + 2'd1;
          case (phase_q)
            2'd0: begin
              umin_d  = div_rsp.quot;
              rz_d[0] = rem_zero;
            end
            2'd1: rz_d[1] = rem_zero;
            default: begin
              umax_d     = div_rsp.quot;
              cache_ok_d = 1'b1;
              prof_ok_d  = (frag_min_q != '0) && (frag_min_q <= frag_avg_q) &&
                           (frag_avg_q <= frag_max_q) && rz_q[0] && rz_q[1] && rem_zero;
            end
          endcase
        end
      end
      SDecide: begin
        res_d = '{fragment_offset: '0, fragment_length: '0, is_last: 1'b0,
                  status: StIdle};
        if (begin_q) begin
          offset_d = '0;
          active_d = 1'b0;
          if (!prof_ok_q) res_d.status = StBadProfile;
        end else if (!active_q) begin
          res_d.status = StIdle;
        end else if (!prof_ok_q) begin
          active_d     = 1'b0;
          res_d.status = StBadProfile;
        end else if (offset_q >= stream_size_q) begin
          active_d     = 1'b0;
          res_d.status = StIdle;
        end
      end
      SBudget: begin
        prod_d = {{BudW{1'b0}}, frag_min_q} * ProdW'(BudLimit);
      end
      SBudCheck: begin
        if (stream_size_q > OffW'(prod_q)) begin
          res_d.status = StBudget;
        end else if (stream_size_q == '0) begin
          res_d.status  = StFragment;
          res_d.is_last = 1'b1;
        end
      end
      SDrawIssue: begin
        div_req.start = 1'b1;
      end
      SDrawWait: begin
        if (div_rsp.done) rmod_d = div_rsp.rem[FragW-1:0];
      end
      SMul: begin
        mul_d = FragW'(rmod_q * frag_align_q);
      end
      SCut: begin
        res_d.fragment_offset = offset_q;
        res_d.fragment_length = cut_len[FragW-1:0];
        res_d.is_last         = !cut_short;
        res_d.status          = StFragment;
        offset_d              = offset_q + cut_len;
        active_d              = cut_short;
      end
      SEmit: begin
      end
      default: begin
      end
    endcase
    if (cfg_prof_wr) cache_ok_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      frag_min_q    <= '0;
      frag_avg_q    <= '0;
      frag_max_q    <= '0;
      frag_align_q  <= '0;
      stream_size_q <= '0;
      offset_q      <= '0;
      active_q      <= 1'b0;
      cache_ok_q    <= 1'b0;
      prof_ok_q     <= 1'b0;
      phase_q       <= 2'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      offset_q   <= offset_d;
      active_q   <= active_d;
      cache_ok_q <= cache_ok_d;
      prof_ok_q  <= prof_ok_d;
      phase_q    <= phase_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFragMin:    frag_min_q    <= cfg_wdata_i[FragW-1:0];
          CfgFragAvg:    frag_avg_q    <= cfg_wdata_i[FragW-1:0];
          CfgFragMax:    frag_max_q    <= cfg_wdata_i[FragW-1:0];
          CfgFragAlign:  frag_align_q  <= cfg_wdata_i[FragW-1:0];
          CfgStreamSize: stream_size_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (state_q == SEmit && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    umin_q <= umin_d;
    umax_q <= umax_d;
    rz_q   <= rz_d;
    prod_q <= prod_d;
    rmod_q <= rmod_d;
    mul_q  <= mul_d;
    res_q  <= res_d;
    if (accept) begin
      draw_q  <= in_data_i.draw_value;
      begin_q <= in_data_i.begin_split;
    end
    if (state_q == SEmit && (!out_valid_q || out_ready_i)) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input ready right after a transfer");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StFragment) |->
      (out_data_o.fragment_offset == '0 && out_data_o.fragment_length == '0 &&
       !out_data_o.is_last))
    else $error("non-fragment status with nonzero payload");

  a_units_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDrawIssue) |-> (cache_ok_q && prof_ok_q && umin_q <= umax_q))
    else $error("draw reduction started without a valid profile");

endmodule

// File: sim/keyed_random_fragment_splitter_unit_test.sv
`timescale 1ns / 1ps
// Testbench of the keyed random fragment splitter: predicted fragments checked per result transfer.
module keyed_random_fragment_splitter_unit_test import krfs_pkg::*; ();

  localparam longint unsigned BudgetDraws  = 64'(MaxChunksDefault) * DrawsPerChunk;
  localparam int unsigned     SettleCycles = 4;
  localparam int unsigned     DrainLimit   = 20000;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  krfs_in_t            in_data    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b1;
  krfs_out_t           out_data;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  logic [FragW-1:0] cfg_min   = '0;
  logic [FragW-1:0] cfg_avg   = '0;
  logic [FragW-1:0] cfg_max   = '0;
  logic [FragW-1:0] cfg_align = '0;
  logic [OffW-1:0]  cfg_size  = '0;
  logic [OffW-1:0]  cur_offset = '0;
  logic             splitting  = 1'b0;

  krfs_out_t   expected_fragments[$];
  krfs_out_t   want_frag;
  int unsigned mismatches     = 0;
  int unsigned fragments_sent = 0;
  logic        idling         = 1'b1;
  int unsigned ready_hold     = 0;

  keyed_random_fragment_splitter_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic profile_valid();
    if (cfg_align == 0 || cfg_min == 0) return 1'b0;
    if (cfg_min > cfg_avg || cfg_avg > cfg_max) return 1'b0;
    return (cfg_min % cfg_align) == 0 && (cfg_avg % cfg_align) == 0 &&
           (cfg_max % cfg_align) == 0;
  endfunction

  function automatic krfs_out_t cut_fragment(input logic [FragW-1:0] draw);
    krfs_out_t        frag;
    logic [OffW-1:0]  umin, umax, span, wanted, left, len;
    umin   = 64'(cfg_min / cfg_align);
    umax   = 64'(cfg_max / cfg_align);
    span   = umax - umin + 1;
    wanted = (umin + 64'(draw) % span) * 64'(cfg_align);
    left   = cfg_size - cur_offset;
    len    = (wanted < left) ? wanted : left;
    frag                 = '0;
    frag.status          = StFragment;
    frag.fragment_offset = cur_offset;
    frag.fragment_length = len[FragW-1:0];
    frag.is_last         = (len == left);
    cur_offset           = cur_offset + len;
    splitting            = !frag.is_last;
    return frag;
  endfunction

  function automatic krfs_out_t predict_fragment(input krfs_in_t item);
    krfs_out_t       frag;
    logic [OffW-1:0] chunks;
    frag        = '0;
    frag.status = StFragment;
    if (item.begin_split) begin
      splitting  = 1'b0;
      cur_offset = '0;
      if (!profile_valid()) begin
        frag.status = StBadProfile;
      end else begin
        chunks = cfg_size / cfg_min + ((cfg_size % cfg_min) != 0 ? 64'd1 : 64'd0);
        if (chunks >= BudgetDraws) frag.status = StBudget;
        else if (cfg_size == 0) frag.is_last = 1'b1;
        else frag = cut_fragment(item.draw_value);
      end
    end else if (!splitting) begin
      frag.status = StIdle;
    end else if (!profile_valid()) begin
      splitting   = 1'b0;
      frag.status = StBadProfile;
    end else if (cur_offset >= cfg_size) begin
      splitting   = 1'b0;
      frag.status = StIdle;
    end else begin
      frag = cut_fragment(item.draw_value);
    end
    return frag;
  endfunction

  task automatic send_draw(input logic [FragW-1:0] draw, input logic start);
    krfs_in_t  item;
    krfs_out_t frag;
    item.draw_value  = draw;
    item.begin_split = start;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    frag = predict_fragment(item);
    expected_fragments = {expected_fragments, frag};
    fragments_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_profile(input logic [FragW-1:0] mn, av, mx, al,
                              input logic [OffW-1:0] sz);
    in_valid <= 1'b0;
    while (expected_fragments.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    write_reg(CfgFragMin, 64'(mn));
    write_reg(CfgFragAvg, 64'(av));
    write_reg(CfgFragMax, 64'(mx));
    write_reg(CfgFragAlign, 64'(al));
    write_reg(CfgStreamSize, sz);
    cfg_we    <= 1'b0;
    cfg_min   = mn;
    cfg_avg   = av;
    cfg_max   = mx;
    cfg_align = al;
    cfg_size  = sz;
  endtask

  task automatic test_profile_checks();
    send_draw($urandom, 1'b1);
    load_profile(0, 8, 16, 4, 100);
    send_draw($urandom, 1'b1);
    load_profile(8, 8, 16, 0, 100);
    send_draw($urandom, 1'b1);
    load_profile(16, 8, 16, 4, 100);
    send_draw($urandom, 1'b1);
    load_profile(8, 32, 16, 4, 100);
    send_draw($urandom, 1'b1);
    load_profile(6, 8, 16, 4, 100);
    send_draw($urandom, 1'b1);
    load_profile(8, 10, 16, 4, 100);
    send_draw($urandom, 1'b1);
    load_profile(8, 12, 18, 4, 100);
    send_draw($urandom, 1'b1);
  endtask

  task automatic test_draw_budget();
    load_profile(4, 8, 8, 4, 64'd4 * 32767);
    send_draw($urandom, 1'b1);
    load_profile(4, 8, 8, 4, 64'd4 * 32767 + 1);
    send_draw($urandom, 1'b1);
    load_profile(4, 8, 8, 4, '1);
    send_draw($urandom, 1'b1);
    load_profile(4, 8, 8, 4, 0);
    send_draw($urandom, 1'b1);
    send_draw($urandom, 1'b0);
  endtask

  task automatic test_extreme_fields();
    load_profile(1, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32767);
    send_draw(32'h0000_0000, 1'b1);
    send_draw(32'hFFFF_FFFF, 1'b0);
    send_draw(32'hFFFF_FFFE, 1'b0);
    load_profile('1, '1, '1, '1, 64'(32'hFFFF_FFFF) * 32767 - 5);
    send_draw($urandom, 1'b1);
  endtask

  task automatic test_midsplit_changes();
    load_profile('1, '1, '1, '1, 1);
    send_draw($urandom, 1'b0);
    load_profile(64, 128, 256, 64, 10000);
    send_draw($urandom, 1'b1);
    load_profile(64, 512, 256, 64, 10000);
    send_draw($urandom, 1'b0);
    send_draw($urandom, 1'b0);
  endtask

  task automatic test_random_splits(input int unsigned quota, input logic allow_idle);
    logic [FragW-1:0] step_sz, lo, hi, mn, av, mx;
    logic [OffW-1:0]  sz;
    int unsigned      steps, kind;
    while (fragments_sent < quota) begin
      idling <= allow_idle && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      case (kind)
        0: begin
          mn      = $urandom;
          av      = $urandom;
          mx      = $urandom;
          step_sz = $urandom_range(0, 4);
          sz      = $urandom_range(0, 1000);
        end
        1: begin
          step_sz = $urandom_range(1, 64);
          mn      = step_sz * $urandom_range(1, 4);
          av      = mn;
          mx      = mn + step_sz * $urandom_range(0, 4);
          sz      = 64'(mn) * 32767 + $urandom_range(0, 2) - 1;
        end
        2: begin
          step_sz = 1;
          mn      = $urandom_range(1, 1 << 16);
          av      = mn + $urandom_range(0, 1 << 20);
          mx      = 32'hFFFF_FFFF;
          sz      = 64'($urandom_range(0, 30000)) * mn + $urandom_range(0, mn);
        end
        default: begin
          step_sz = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 20))
                                         : $urandom_range(1, 5000);
          lo = $urandom_range(1, 32);
          hi = lo + $urandom_range(0, 32);
          mn = lo * step_sz;
          mx = hi * step_sz;
          av = $urandom_range(lo, hi) * step_sz;
          case ($urandom_range(0, 9))
            0:       sz = 0;
            1:       sz = {$urandom, $urandom};
            default: sz = 64'($urandom_range(0, 8)) * mn + $urandom_range(0, mx);
          endcase
        end
      endcase
      load_profile(mn, av, mx, step_sz, sz);
      send_draw($urandom, 1'b1);
      steps = 0;
      while (splitting && steps < 80) begin
        case ($urandom_range(0, 39))
          0: send_draw($urandom, 1'b1);
          1: begin
            kind = $urandom_range(0, 2);
            if (kind == 0) sz = cur_offset - $urandom_range(0, 1);
            else if (kind == 1) step_sz = 0;
            else sz = sz + $urandom_range(0, mx);
            load_profile(mn, av, mx, step_sz, sz);
          end
          default: send_draw($urandom, 1'b0);
        endcase
        steps++;
      end
      repeat ($urandom_range(0, 2)) send_draw($urandom, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_fragments.size() == 0) begin
        $error("result transfer with no fragment expected");
        mismatches++;
      end else begin
        want_frag = expected_fragments.pop_front();
        if (out_data.fragment_offset !== want_frag.fragment_offset) begin
          $error("fragment_offset: expected %0h, got %0h",
                 want_frag.fragment_offset, out_data.fragment_offset);
          mismatches++;
        end
        if (out_data.fragment_length !== want_frag.fragment_length) begin
          $error("fragment_length: expected %0h, got %0h",
                 want_frag.fragment_length, out_data.fragment_length);
          mismatches++;
        end
        if (out_data.is_last !== want_frag.is_last) begin
          $error("is_last: expected %0b, got %0b", want_frag.is_last, out_data.is_last);
          mismatches++;
        end
        if (out_data.status !== want_frag.status) begin
          $error("status: expected %0d, got %0d", want_frag.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_profile_checks();
    test_draw_budget();
    test_extreme_fields();
    test_midsplit_changes();
    test_random_splits(1050, 1'b1);
    test_random_splits(fragments_sent + 100, 1'b0);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_fragments.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_fragments.size() == 0) begin
      $display("keyed_random_fragment_splitter_unit_test passed");
    end else begin
      $display("keyed_random_fragment_splitter_unit_test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("keyed_random_fragment_splitter_unit_test failed");
    $finish;
  end

endmodule
